@@ design/layer_priority_blend_compositor_defines.svh @@
// Assertion macros shared by the layer priority blend compositor RTL.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef LAYER_PRIORITY_BLEND_COMPOSITOR_DEFINES_SVH
`define LAYER_PRIORITY_BLEND_COMPOSITOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPBC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lpbc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lpbc: next-cycle check failed");

`endif

@@ design/lpbc_pkg.sv @@
// Shared types, codes and helper functions of the layer priority blend compositor.
// Used by every interface and module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lpbc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned RGB555_W   = 15;
  localparam int unsigned RGB666_W   = 18;
  localparam int unsigned CHAN_W     = 6;
  localparam int unsigned COEFF_MAX  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND_CTRL  = 3'd0,
    REG_ALPHA_COEFF = 3'd1,
    REG_BRIGHT      = 3'd2,
    REG_BG_PRIO     = 3'd3,
    REG_OBJ_ENABLE  = 3'd4,
    REG_BACKDROP    = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EFFECT_NONE     = 2'd0,
    EFFECT_ALPHA    = 2'd1,
    EFFECT_BRIGHTEN = 2'd2,
    EFFECT_DARKEN   = 2'd3
  } effect_e;

  typedef enum logic [2:0] {
    LAYER_BG0      = 3'd0,
    LAYER_BG1      = 3'd1,
    LAYER_BG2      = 3'd2,
    LAYER_BG3      = 3'd3,
    LAYER_OBJ      = 3'd4,
    LAYER_BACKDROP = 3'd5
  } layer_e;

  localparam logic [2:0] PRIO_BACKDROP = 3'd4;

  typedef struct packed {
    logic [13:0]         blend_ctrl;
    logic [12:0]         alpha_coeffs;
    logic [4:0]          bright_coeff;
    logic [7:0]          bg_prio;
    logic                obj_enable;
    logic [RGB555_W-1:0] backdrop;
  } cfg_t;

  typedef struct packed {
    logic [7:0]          pixel_x;
    logic [7:0]          line_number;
    logic [RGB555_W-1:0] bg0_colour;
    logic [RGB555_W-1:0] bg1_colour;
    logic [RGB555_W-1:0] bg2_colour;
    logic [RGB555_W-1:0] bg3_colour;
    logic [3:0]          bg_opaque;
    logic [3:0]          layer_window_mask;
    logic [RGB555_W-1:0] obj_colour;
    logic                obj_opaque;
    logic [1:0]          obj_priority;
    logic                obj_semi_transparent;
  } px_t;

  typedef struct packed {
    logic [RGB666_W-1:0] top_colour;
    logic [RGB666_W-1:0] bot_colour;
    logic                top_first;
    logic                bot_second;
    logic                semi;
  } sel_t;

  function automatic logic [RGB666_W-1:0] widen(input logic [RGB555_W-1:0] c);
    widen = {c[14:10], 1'b0, c[9:5], 1'b0, c[4:0], 1'b0};
  endfunction

  function automatic logic [4:0] clamp16(input logic [4:0] v);
    clamp16 = (v > 5'(COEFF_MAX)) ? 5'(COEFF_MAX) : v;
  endfunction

endpackage

`default_nettype wire

@@ design/lpbc_in_if.sv @@
// Pixel input channel: valid/ready handshake with the per-pixel layer word.
// Depends on lpbc_pkg for the colour width.
`timescale 1ns / 1ps
`default_nettype none

interface lpbc_in_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    pixel_x;
  logic [7:0]                    line_number;
  logic [lpbc_pkg::RGB555_W-1:0] bg0_colour;
  logic [lpbc_pkg::RGB555_W-1:0] bg1_colour;
  logic [lpbc_pkg::RGB555_W-1:0] bg2_colour;
  logic [lpbc_pkg::RGB555_W-1:0] bg3_colour;
  logic [3:0]                    bg_opaque;
  logic [3:0]                    layer_window_mask;
  logic [lpbc_pkg::RGB555_W-1:0] obj_colour;
  logic                          obj_opaque;
  logic [1:0]                    obj_priority;
  logic                          obj_semi_transparent;

  modport source (
    output valid, pixel_x, line_number, bg0_colour, bg1_colour, bg2_colour, bg3_colour,
           bg_opaque, layer_window_mask, obj_colour, obj_opaque, obj_priority,
           obj_semi_transparent,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, line_number, bg0_colour, bg1_colour, bg2_colour, bg3_colour,
           bg_opaque, layer_window_mask, obj_colour, obj_opaque, obj_priority,
           obj_semi_transparent,
    output ready
  );
endinterface

`default_nettype wire

@@ design/lpbc_out_if.sv @@
// Result channel: valid/ready handshake with the composed rgb666 pixel word.
// Depends on lpbc_pkg for the colour width.
`timescale 1ns / 1ps
`default_nettype none

interface lpbc_out_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    out_x;
  logic [7:0]                    out_line;
  logic [lpbc_pkg::RGB666_W-1:0] out_colour;

  modport source (
    output valid, out_x, out_line, out_colour,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_line, out_colour,
    output ready
  );
endinterface

`default_nettype wire

@@ design/lpbc_cfg_regs.sv @@
// Configuration register file of the compositor, written through a plain write port.
// Depends on lpbc_pkg for the register codes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module lpbc_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [lpbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lpbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lpbc_pkg::cfg_t                       cfg
);

  lpbc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lpbc_pkg::REG_BLEND_CTRL:  cfg_r.blend_ctrl   <= cfg_wdata[13:0];
        lpbc_pkg::REG_ALPHA_COEFF: cfg_r.alpha_coeffs <= cfg_wdata[12:0];
        lpbc_pkg::REG_BRIGHT:      cfg_r.bright_coeff <= cfg_wdata[4:0];
        lpbc_pkg::REG_BG_PRIO:     cfg_r.bg_prio      <= cfg_wdata[7:0];
        lpbc_pkg::REG_OBJ_ENABLE:  cfg_r.obj_enable   <= cfg_wdata[0];
        lpbc_pkg::REG_BACKDROP:    cfg_r.backdrop     <= cfg_wdata[14:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ design/lpbc_layer_select.sv @@
// Picks the two front-most layers of one pixel and widens their colours to rgb666.
// Depends on lpbc_pkg for the layer codes, cfg_t, px_t and sel_t.
`timescale 1ns / 1ps
`default_nettype none

module lpbc_layer_select (
  input  wire lpbc_pkg::cfg_t cfg,
  input  wire lpbc_pkg::px_t  px,
  output lpbc_pkg::sel_t      sel
);

  lpbc_pkg::layer_e              tgt0;
  lpbc_pkg::layer_e              tgt1;
  logic [2:0]                    pr0;
  logic [2:0]                    pr1;
  logic [2:0]                    p;
  logic [2:0]                    obj_p;
  logic [3:0]                    visible;
  logic                          semi;
  logic [5:0]                    first_mask;
  logic [5:0]                    second_mask;

  assign visible     = px.bg_opaque & px.layer_window_mask;
  assign obj_p       = {1'b0, px.obj_priority};
  assign first_mask  = cfg.blend_ctrl[5:0];
  assign second_mask = cfg.blend_ctrl[13:8];

  // Backgrounds are scanned from bg3 down so that the lower index wins ties.
  always_comb begin
    tgt0 = lpbc_pkg::LAYER_BACKDROP;
    tgt1 = lpbc_pkg::LAYER_BACKDROP;
    pr0  = lpbc_pkg::PRIO_BACKDROP;
    pr1  = lpbc_pkg::PRIO_BACKDROP;
    semi = 1'b0;
    p    = '0;
    for (int i = 3; i >= 0; i--) begin
      p = {1'b0, cfg.bg_prio[2*i +: 2]};
      if (visible[i]) begin
        if (p <= pr0) begin
          tgt1 = tgt0;
          pr1  = pr0;
          tgt0 = lpbc_pkg::layer_e'(3'(i));
          pr0  = p;
        end else if (p <= pr1) begin
          tgt1 = lpbc_pkg::layer_e'(3'(i));
          pr1  = p;
        end
      end
    end
    if (cfg.obj_enable && px.obj_opaque) begin
      if (obj_p <= pr0) begin
        tgt1 = tgt0;
        tgt0 = lpbc_pkg::LAYER_OBJ;
        semi = px.obj_semi_transparent;
      end else if (obj_p <= pr1) begin
        tgt1 = lpbc_pkg::LAYER_OBJ;
      end
    end
  end

  function automatic logic [lpbc_pkg::RGB555_W-1:0] pick(
    input lpbc_pkg::layer_e      t,
    input lpbc_pkg::px_t         x,
    input logic [lpbc_pkg::RGB555_W-1:0] backdrop
  );
    case (t)
      lpbc_pkg::LAYER_BG0: pick = x.bg0_colour;
      lpbc_pkg::LAYER_BG1: pick = x.bg1_colour;
      lpbc_pkg::LAYER_BG2: pick = x.bg2_colour;
      lpbc_pkg::LAYER_BG3: pick = x.bg3_colour;
      lpbc_pkg::LAYER_OBJ: pick = x.obj_colour;
      default:             pick = backdrop;
    endcase
  endfunction

  assign sel.top_colour = lpbc_pkg::widen(pick(tgt0, px, cfg.backdrop));
  assign sel.bot_colour = lpbc_pkg::widen(pick(tgt1, px, cfg.backdrop));
  assign sel.top_first  = first_mask[tgt0] || semi;
  assign sel.bot_second = second_mask[tgt1];
  assign sel.semi       = semi;

endmodule

`default_nettype wire

@@ design/lpbc_blend.sv @@
// Colour effect unit: alpha blend, brighten or darken on the three rgb666 channels.
// Depends on lpbc_pkg for cfg_t, sel_t, the effect codes and clamp16.
`timescale 1ns / 1ps
`default_nettype none

module lpbc_blend (
  input  wire lpbc_pkg::cfg_t                 cfg,
  input  wire lpbc_pkg::sel_t                 sel,
  output logic [lpbc_pkg::RGB666_W-1:0]       colour
);

  localparam int unsigned CW = lpbc_pkg::CHAN_W;

  lpbc_pkg::effect_e             effect;
  lpbc_pkg::effect_e             mode;
  logic [4:0]                    eva;
  logic [4:0]                    evb;
  logic [4:0]                    evy;
  logic [lpbc_pkg::RGB666_W-1:0] alpha_c;
  logic [lpbc_pkg::RGB666_W-1:0] bright_c;
  logic [lpbc_pkg::RGB666_W-1:0] dark_c;

  assign effect = lpbc_pkg::effect_e'(cfg.blend_ctrl[7:6]);
  assign eva    = lpbc_pkg::clamp16(cfg.alpha_coeffs[4:0]);
  assign evb    = lpbc_pkg::clamp16(cfg.alpha_coeffs[12:8]);
  assign evy    = lpbc_pkg::clamp16(cfg.bright_coeff);

  for (genvar k = 0; k < 3; k++) begin : g_chan
    logic [CW-1:0] t;
    logic [CW-1:0] b;
    logic [10:0]   a_sum;
    logic [6:0]    a_q;
    logic [10:0]   up_sum;
    logic [10:0]   dn_sum;

    assign t      = sel.top_colour[k*CW +: CW];
    assign b      = sel.bot_colour[k*CW +: CW];
    assign a_sum  = 11'(t) * 11'(eva) + 11'(b) * 11'(evb) + 11'd8;
    assign a_q    = a_sum[10:4];
    assign up_sum = 11'(6'd63 - t) * 11'(evy) + 11'd8;
    assign dn_sum = 11'(t) * 11'(evy) + 11'd7;

    assign alpha_c[k*CW +: CW]  = (a_q > 7'd63) ? 6'd63 : a_q[5:0];
    assign bright_c[k*CW +: CW] = t + up_sum[9:4];
    assign dark_c[k*CW +: CW]   = t - dn_sum[9:4];
  end

  // A semi-transparent object over a second target always alpha-blends.
  always_comb begin
    if (sel.semi && sel.bot_second) begin
      mode = lpbc_pkg::EFFECT_ALPHA;
    end else if (!sel.top_first || (effect == lpbc_pkg::EFFECT_ALPHA && !sel.bot_second)) begin
      mode = lpbc_pkg::EFFECT_NONE;
    end else begin
      mode = effect;
    end
  end

  always_comb begin
    case (mode)
      lpbc_pkg::EFFECT_ALPHA:    colour = alpha_c;
      lpbc_pkg::EFFECT_BRIGHTEN: colour = bright_c;
      lpbc_pkg::EFFECT_DARKEN:   colour = dark_c;
      default:                   colour = sel.top_colour;
    endcase
  end

endmodule

`default_nettype wire

@@ design/layer_priority_blend_compositor.sv @@
// Layer priority blend compositor top level: input register, layer pick and blend, result register.
// Depends on lpbc_pkg, lpbc_in_if, lpbc_out_if, lpbc_cfg_regs, lpbc_layer_select and lpbc_blend.
// The input register holds an accepted pixel word and the result register its blended result.
// Throughput: one word per cycle unless the output stalls; the registers form a two-stage pipeline.
// Synchronous active-low reset clears both stage valid flags and all configuration registers.
`timescale 1ns / 1ps
`default_nettype none

`include "layer_priority_blend_compositor_defines.svh"

module layer_priority_blend_compositor (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [lpbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lpbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  lpbc_in_if.sink                              in_px,
  lpbc_out_if.source                           out_px
);

  lpbc_pkg::cfg_t                cfg;
  lpbc_pkg::sel_t                sel;
  lpbc_pkg::px_t                 in_word;
  lpbc_pkg::px_t                 s1_px_r;
  logic                          s1_valid_r;
  logic                          s1_ready;
  logic                          s2_ready;
  logic                          out_valid_r;
  logic [7:0]                    out_x_r;
  logic [7:0]                    out_line_r;
  logic [lpbc_pkg::RGB666_W-1:0] out_colour_r;
  logic [lpbc_pkg::RGB666_W-1:0] out_colour_nxt;

  lpbc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_word.pixel_x              = in_px.pixel_x;
  assign in_word.line_number          = in_px.line_number;
  assign in_word.bg0_colour           = in_px.bg0_colour;
  assign in_word.bg1_colour           = in_px.bg1_colour;
  assign in_word.bg2_colour           = in_px.bg2_colour;
  assign in_word.bg3_colour           = in_px.bg3_colour;
  assign in_word.bg_opaque            = in_px.bg_opaque;
  assign in_word.layer_window_mask    = in_px.layer_window_mask;
  assign in_word.obj_colour           = in_px.obj_colour;
  assign in_word.obj_opaque           = in_px.obj_opaque;
  assign in_word.obj_priority         = in_px.obj_priority;
  assign in_word.obj_semi_transparent = in_px.obj_semi_transparent;

  assign s2_ready    = !out_valid_r || out_px.ready;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_px.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_px.valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_px.valid) begin
      s1_px_r <= in_word;
    end
    if (s2_ready && s1_valid_r) begin
      out_x_r      <= s1_px_r.pixel_x;
      out_line_r   <= s1_px_r.line_number;
      out_colour_r <= out_colour_nxt;
    end
  end

  lpbc_layer_select u_layer_select (
    .cfg (cfg),
    .px  (s1_px_r),
    .sel (sel)
  );

  lpbc_blend u_blend (
    .cfg    (cfg),
    .sel    (sel),
    .colour (out_colour_nxt)
  );

  assign out_px.valid      = out_valid_r;
  assign out_px.out_x      = out_x_r;
  assign out_px.out_line   = out_line_r;
  assign out_px.out_colour = out_colour_r;

  `LPBC_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_px.valid && in_px.ready, s1_valid_r)
  `LPBC_ASSERT_NEXT(a_s1_holds_on_stall, clk, rst_n, s1_valid_r && !s2_ready,
                    s1_valid_r && $stable(s1_px_r))
  `LPBC_ASSERT_NEXT(a_s1_moves_to_out, clk, rst_n, s1_valid_r && s2_ready, out_valid_r)
  `LPBC_ASSERT_NEXT(a_out_drains_empty, clk, rst_n, !s1_valid_r && out_px.ready, !out_valid_r)
  `LPBC_ASSERT_NEXT(a_x_passes_through, clk, rst_n, s1_valid_r && s2_ready,
                    out_x_r == $past(s1_px_r.pixel_x))

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for the layer priority blend compositor: streams pixel words under
// several register settings and checks every result word against an in-bench predictor.
// Depends on lpbc_pkg, lpbc_in_if, lpbc_out_if and the compositor RTL.
`timescale 1ns / 1ps

module tb_top;
  import lpbc_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned TAIL_CYCLES     = 10;
  localparam int unsigned PRINT_CAP       = 100;

  typedef struct packed {
    logic [7:0]          x_pos;
    logic [7:0]          scanline;
    logic [RGB666_W-1:0] colour;
  } composed_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lpbc_in_if  in_px();
  lpbc_out_if out_px();

  cfg_t      model;
  px_t       pixel_backlog[$];
  composed_t composed_due[$];
  px_t       offered;
  bit        idling_on = 1'b1;
  int        gap_left = 0;
  int        stall_left = 0;
  int        hold_left = 0;
  int        hold_requests = 0;
  int        hold_served = 0;
  int        quiet_cycles = 0;
  int        mismatch_count = 0;

  layer_priority_blend_compositor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_px     (in_px),
    .out_px    (out_px)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [4:0] pick_coeff();
    if ($urandom_range(0, 4) == 0) begin
      return 5'($urandom_range(17, 31));
    end
    return 5'($urandom_range(0, 16));
  endfunction

  function automatic logic [RGB555_W-1:0] pick_rgb555();
    case ($urandom_range(0, 7))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      default: begin
        return RGB555_W'($urandom);
      end
    endcase
  endfunction

  function automatic px_t random_pixel();
    px_t p;
    p.pixel_x              = 8'($urandom);
    p.line_number          = 8'($urandom_range(0, 191));
    p.bg0_colour           = pick_rgb555();
    p.bg1_colour           = pick_rgb555();
    p.bg2_colour           = pick_rgb555();
    p.bg3_colour           = pick_rgb555();
    p.bg_opaque            = 4'($urandom);
    p.layer_window_mask    = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hf;
    p.obj_colour           = pick_rgb555();
    p.obj_opaque           = ($urandom_range(0, 3) != 0);
    p.obj_priority         = 2'($urandom);
    p.obj_semi_transparent = 1'($urandom);
    return p;
  endfunction

  function automatic int unsigned cap16(logic [4:0] v);
    return (v > 5'd16) ? 16 : int'(v);
  endfunction

  function automatic logic [CHAN_W-1:0] blend_channel(int unsigned t, int unsigned b,
                                                      effect_e eff);
    int unsigned eva;
    int unsigned evb;
    int unsigned evy;
    int unsigned c;
    eva = cap16(model.alpha_coeffs[4:0]);
    evb = cap16(model.alpha_coeffs[12:8]);
    evy = cap16(model.bright_coeff);
    case (eff)
      EFFECT_ALPHA: begin
        c = (t * eva + b * evb + 8) / 16;
        if (c > 63) begin
          c = 63;
        end
      end
      EFFECT_BRIGHTEN: begin
        c = t + ((63 - t) * evy + 8) / 16;
      end
      EFFECT_DARKEN: begin
        c = t - (t * evy + 7) / 16;
      end
      default: begin
        c = t;
      end
    endcase
    return c[CHAN_W-1:0];
  endfunction

  function automatic logic [RGB666_W-1:0] mix_colour(logic [RGB666_W-1:0] top_c,
                                                     logic [RGB666_W-1:0] bot_c,
                                                     effect_e eff);
    logic [RGB666_W-1:0] res;
    for (int k = 0; k < 3; k++) begin
      res[CHAN_W*k +: CHAN_W] = blend_channel(top_c[CHAN_W*k +: CHAN_W],
                                              bot_c[CHAN_W*k +: CHAN_W], eff);
    end
    return res;
  endfunction

  function automatic logic [RGB666_W-1:0] layer_rgb666(px_t p, layer_e l);
    logic [RGB555_W-1:0] c;
    logic [RGB666_W-1:0] res;
    case (l)
      LAYER_BG0: begin
        c = p.bg0_colour;
      end
      LAYER_BG1: begin
        c = p.bg1_colour;
      end
      LAYER_BG2: begin
        c = p.bg2_colour;
      end
      LAYER_BG3: begin
        c = p.bg3_colour;
      end
      LAYER_OBJ: begin
        c = p.obj_colour;
      end
      default: begin
        c = model.backdrop;
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      res[CHAN_W*k +: CHAN_W] = {c[5*k +: 5], 1'b0};
    end
    return res;
  endfunction

  function automatic composed_t expected_word(px_t p);
    layer_e              top_l;
    layer_e              bot_l;
    int unsigned         top_p;
    int unsigned         bot_p;
    int unsigned         pr;
    logic                semi;
    logic                top_sel;
    logic                bot_sel;
    effect_e             eff;
    logic [RGB666_W-1:0] top_c;
    logic [RGB666_W-1:0] bot_c;
    composed_t           r;
    top_l = LAYER_BACKDROP;
    bot_l = LAYER_BACKDROP;
    top_p = PRIO_BACKDROP;
    bot_p = PRIO_BACKDROP;
    semi  = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      pr = model.bg_prio[2*i +: 2];
      if (p.bg_opaque[i] && p.layer_window_mask[i]) begin
        if (pr <= top_p) begin
          bot_l = top_l;
          bot_p = top_p;
          top_l = layer_e'(i);
          top_p = pr;
        end else if (pr <= bot_p) begin
          bot_l = layer_e'(i);
          bot_p = pr;
        end
      end
    end
    if (model.obj_enable && p.obj_opaque) begin
      if (p.obj_priority <= top_p) begin
        bot_l = top_l;
        top_l = LAYER_OBJ;
        semi  = p.obj_semi_transparent;
      end else if (p.obj_priority <= bot_p) begin
        bot_l = LAYER_OBJ;
      end
    end
    eff     = effect_e'(model.blend_ctrl[7:6]);
    top_sel = model.blend_ctrl[int'(top_l)] || semi;
    bot_sel = model.blend_ctrl[8 + int'(bot_l)];
    top_c   = layer_rgb666(p, top_l);
    bot_c   = layer_rgb666(p, bot_l);
    r.x_pos    = p.pixel_x;
    r.scanline = p.line_number;
    if (semi && bot_sel) begin
      r.colour = mix_colour(top_c, bot_c, EFFECT_ALPHA);
    end else if (!top_sel || eff == EFFECT_NONE || (eff == EFFECT_ALPHA && !bot_sel)) begin
      r.colour = top_c;
    end else begin
      r.colour = mix_colour(top_c, bot_c, eff);
    end
    return r;
  endfunction

  task automatic report(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
  endtask

  task automatic apply_settings(cfg_t s);
    write_reg(REG_BLEND_CTRL, CFG_DATA_W'(s.blend_ctrl));
    write_reg(REG_ALPHA_COEFF, CFG_DATA_W'(s.alpha_coeffs));
    write_reg(REG_BRIGHT, CFG_DATA_W'(s.bright_coeff));
    write_reg(REG_BG_PRIO, CFG_DATA_W'(s.bg_prio));
    write_reg(REG_OBJ_ENABLE, CFG_DATA_W'(s.obj_enable));
    write_reg(REG_BACKDROP, CFG_DATA_W'(s.backdrop));
    @(posedge clk);
    cfg_we <= 1'b0;
    model = s;
  endtask

  task automatic queue_random(int n);
    @(negedge clk);
    repeat (n) begin
      pixel_backlog.push_back(random_pixel());
    end
  endtask

  task automatic drain();
    do begin
      @(negedge clk);
    end while (pixel_backlog.size() != 0 || composed_due.size() != 0 || in_px.valid);
    repeat (4) @(negedge clk);
  endtask

  // The sender offers the next word as soon as the current one is taken, unless it inserts a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_px.valid <= 1'b0;
    end else begin
      if (in_px.valid && in_px.ready) begin
        composed_due.push_back(expected_word(offered));
      end
      if (!in_px.valid || in_px.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_px.valid <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 6);
          in_px.valid <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          offered = pixel_backlog.pop_front();
          in_px.pixel_x              <= offered.pixel_x;
          in_px.line_number          <= offered.line_number;
          in_px.bg0_colour           <= offered.bg0_colour;
          in_px.bg1_colour           <= offered.bg1_colour;
          in_px.bg2_colour           <= offered.bg2_colour;
          in_px.bg3_colour           <= offered.bg3_colour;
          in_px.bg_opaque            <= offered.bg_opaque;
          in_px.layer_window_mask    <= offered.layer_window_mask;
          in_px.obj_colour           <= offered.obj_colour;
          in_px.obj_opaque           <= offered.obj_opaque;
          in_px.obj_priority         <= offered.obj_priority;
          in_px.obj_semi_transparent <= offered.obj_semi_transparent;
          in_px.valid                <= 1'b1;
        end else begin
          in_px.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    composed_t want;
    if (!rst_n) begin
      out_px.ready <= 1'b0;
    end else begin
      if (out_px.valid && out_px.ready) begin
        if (composed_due.size() == 0) begin
          report($sformatf("result word x=%0d line=%0d with nothing expected",
                           out_px.out_x, out_px.out_line));
        end else begin
          want = composed_due.pop_front();
          if (out_px.out_x !== want.x_pos) begin
            report($sformatf("out_x %0d, expected %0d", out_px.out_x, want.x_pos));
          end
          if (out_px.out_line !== want.scanline) begin
            report($sformatf("out_line %0d, expected %0d", out_px.out_line, want.scanline));
          end
          if (out_px.out_colour !== want.colour) begin
            report($sformatf("out_colour 0x%05h, expected 0x%05h at x=%0d line=%0d",
                             out_px.out_colour, want.colour, want.x_pos, want.scanline));
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_OFF_CYCLES;
        out_px.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_px.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_px.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_px.ready <= 1'b0;
      end else begin
        out_px.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_px.valid && in_px.ready) || (out_px.valid && out_px.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    cfg_t s;
    px_t  p;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_BLEND_CTRL;
    cfg_wdata    = '0;
    model        = '0;
    out_px.ready = 1'b0;
    in_px.valid  = 1'b0;
    in_px.pixel_x              = '0;
    in_px.line_number          = '0;
    in_px.bg0_colour           = '0;
    in_px.bg1_colour           = '0;
    in_px.bg2_colour           = '0;
    in_px.bg3_colour           = '0;
    in_px.bg_opaque            = '0;
    in_px.layer_window_mask    = '0;
    in_px.obj_colour           = '0;
    in_px.obj_opaque           = 1'b0;
    in_px.obj_priority         = '0;
    in_px.obj_semi_transparent = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Short directed pass, one register setting per effect.
    for (int e = 0; e < 4; e++) begin
      s.blend_ctrl   = {6'b110101, 2'(e), 6'b101011};
      s.alpha_coeffs = {5'd6, 3'b000, 5'd12};
      s.bright_coeff = 5'd9;
      s.bg_prio      = e[1] ? 8'h00 : 8'h1b;
      s.obj_enable   = (effect_e'(e) != EFFECT_DARKEN);
      s.backdrop     = 15'h2d6b;
      apply_settings(s);
      @(negedge clk);
      for (int k = 0; k < 6; k++) begin
        p = random_pixel();
        case (k)
          0: begin
            p = '0;
          end
          1: begin
            p = '1;
            p.line_number  = 8'd191;
            p.obj_priority = 2'd0;
          end
          2: begin
            p.bg_opaque            = 4'b0100;
            p.layer_window_mask    = 4'hf;
            p.obj_opaque           = 1'b1;
            p.obj_priority         = 2'd1;
            p.obj_semi_transparent = 1'b1;
          end
          3: begin
            p.bg_opaque            = 4'b1000;
            p.layer_window_mask    = 4'hf;
            p.obj_opaque           = 1'b1;
            p.obj_priority         = 2'd3;
            p.obj_semi_transparent = 1'b1;
          end
          4: begin
            p.bg_opaque         = 4'hf;
            p.layer_window_mask = 4'b0101;
            p.obj_opaque        = 1'b0;
          end
          default: begin
            p.bg_opaque         = 4'b0011;
            p.layer_window_mask = 4'hf;
            p.obj_opaque        = 1'b0;
          end
        endcase
        pixel_backlog.push_back(p);
      end
      drain();
    end

    apply_settings('0);
    queue_random(100);
    drain();

    s.blend_ctrl   = '1;
    s.alpha_coeffs = 13'h1f1f;
    s.bright_coeff = '1;
    s.bg_prio      = '1;
    s.obj_enable   = 1'b1;
    s.backdrop     = '1;
    apply_settings(s);
    queue_random(150);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      idling_on = (ph < 11) && (ph % 3 != 2);
      s.blend_ctrl   = 14'($urandom);
      s.alpha_coeffs = {pick_coeff(), 3'b000, pick_coeff()};
      s.bright_coeff = pick_coeff();
      s.bg_prio      = 8'($urandom);
      s.obj_enable   = ($urandom_range(0, 3) != 0);
      s.backdrop     = pick_rgb555();
      apply_settings(s);
      queue_random(150);
      if (ph == 5) begin
        repeat (20) @(negedge clk);
        hold_requests++;
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
